[design/qalu_pkg.sv]
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies; used by every module of the block.
`default_nettype none

package qalu_pkg;

	localparam int FRAC_BITS = 8;
	localparam int WORD_W    = 32;
	// Low bits of |product| that still matter after rounding and wrapping.
	localparam int MAG_W     = WORD_W + FRAC_BITS;
	// Divider works on |a| << (FRAC_BITS+1) to get one extra quotient bit for rounding.
	localparam int DIVD_W    = WORD_W + FRAC_BITS + 1;
	// Quotient bits kept: 32 result bits plus the rounding bit.
	localparam int QUO_W     = WORD_W + 1;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_CMP      = 4'd4,
		OP_MIN      = 4'd5,
		OP_MAX      = 4'd6,
		OP_INC      = 4'd7,
		OP_DEC      = 4'd8,
		OP_TO_INT   = 4'd9,
		OP_FROM_INT = 4'd10
	} opcode_t;

	// Request state handed along the divider chain.
	typedef struct packed {
		logic                  is_div;
		logic                  neg;
		logic [WORD_W-1:0]     res;
		logic                  lt;
		logic                  eq;
		logic                  gt;
		logic                  dz;
		logic [WORD_W-1:0]     den;
		logic [DIVD_W-1:0]     dvd;
		logic [WORD_W-1:0]     rem;
		logic [QUO_W-1:0]      quo;
	} chain_t;

endpackage

`default_nettype wire

[design/qalu_front.sv]
// Front end: decode, simple operations, multiply and divider setup.
// Three pipeline stages; depends on qalu_pkg.
`default_nettype none

module qalu_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [3:0]                  req_type,
	input  wire logic [qalu_pkg::WORD_W-1:0] operand_a,
	input  wire logic [qalu_pkg::WORD_W-1:0] operand_b,
	output logic                             out_valid,
	output qalu_pkg::chain_t                 out_data
);
	import qalu_pkg::*;

	chain_t                    c_d;
	logic                      is_mul_d;
	logic signed [2*WORD_W-1:0] prod_d;
	logic signed [WORD_W-1:0]  sa, sb;
	logic [WORD_W-1:0]         abs_a, abs_b;

	logic                      valid_s1, valid_s2, valid_s3;
	chain_t                    c_s1, c_s2, c_s3;
	logic                      is_mul_s1, is_mul_s2;
	logic [2*WORD_W-1:0]       prod_s1;
	logic                      pneg_s2;
	logic [MAG_W-1:0]          mag_s2;

	logic [MAG_W-1:0]          rnd_sum;
	logic [WORD_W-1:0]         rnd_mag;
	chain_t                    c_s2_d;

	assign sa    = operand_a;
	assign sb    = operand_b;
	assign abs_a = operand_a[WORD_W-1] ? (WORD_W'(0) - operand_a) : operand_a;
	assign abs_b = operand_b[WORD_W-1] ? (WORD_W'(0) - operand_b) : operand_b;
	assign prod_d = sa * sb;

	always_comb begin
		c_d        = '0;
		is_mul_d   = 1'b0;
		c_d.den    = abs_b;
		c_d.dvd    = {abs_a, {(FRAC_BITS+1){1'b0}}};
		c_d.neg    = operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
		case (opcode_t'(req_type))
			OP_ADD:      c_d.res = operand_a + operand_b;
			OP_SUB:      c_d.res = operand_a - operand_b;
			OP_MUL:      is_mul_d = 1'b1;
			OP_DIV: begin
				if (operand_b == '0) begin
					c_d.res = operand_a;
					c_d.dz  = 1'b1;
				end else begin
					c_d.is_div = 1'b1;
				end
			end
			OP_CMP: begin
				c_d.lt = sa < sb;
				c_d.eq = sa == sb;
				c_d.gt = sa > sb;
			end
			OP_MIN:      c_d.res = (sa < sb) ? operand_a : operand_b;
			OP_MAX:      c_d.res = (sa > sb) ? operand_a : operand_b;
			OP_INC:      c_d.res = operand_a + WORD_W'(1);
			OP_DEC:      c_d.res = operand_a - WORD_W'(1);
			OP_TO_INT:   c_d.res = sa >>> FRAC_BITS;
			OP_FROM_INT: c_d.res = operand_a << FRAC_BITS;
			default:     c_d.res = '0;
		endcase
	end

	// rounding half away from zero on the magnitude
	assign rnd_sum = mag_s2 + MAG_W'(1 << (FRAC_BITS-1));
	assign rnd_mag = rnd_sum[MAG_W-1:FRAC_BITS];

	always_comb begin
		c_s2_d = c_s2;
		if (is_mul_s2)
			c_s2_d.res = pneg_s2 ? (WORD_W'(0) - rnd_mag) : rnd_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1      <= c_d;
			is_mul_s1 <= is_mul_d;
			prod_s1   <= prod_d;

			c_s2      <= c_s1;
			is_mul_s2 <= is_mul_s1;
			pneg_s2   <= prod_s1[2*WORD_W-1];
			mag_s2    <= prod_s1[2*WORD_W-1] ? (MAG_W'(0) - prod_s1[MAG_W-1:0])
			                                 : prod_s1[MAG_W-1:0];

			c_s3 <= c_s2_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = c_s3;

endmodule

`default_nettype wire

[design/qalu_div_cell.sv]
// One restoring-division cell: develops one quotient bit and passes the request on.
// Depends on qalu_pkg.
`default_nettype none

module qalu_div_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       in_valid,
	input  wire qalu_pkg::chain_t in_data,
	output logic            out_valid,
	output qalu_pkg::chain_t out_data
);
	import qalu_pkg::*;

	logic [WORD_W:0]   rem_ext;
	logic [WORD_W:0]   rem_sub;
	logic              ge;
	chain_t            nxt;
	logic              valid_q;
	chain_t            data_q;

	assign rem_ext = {in_data.rem, in_data.dvd[DIVD_W-1]};
	assign rem_sub = rem_ext - {1'b0, in_data.den};
	assign ge      = rem_ext >= {1'b0, in_data.den};

	always_comb begin
		nxt     = in_data;
		// remainder stays below the divisor, so it fits in a word
		nxt.rem = ge ? rem_sub[WORD_W-1:0] : rem_ext[WORD_W-1:0];
		nxt.dvd = {in_data.dvd[DIVD_W-2:0], 1'b0};
		nxt.quo = {in_data.quo[QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

[design/qalu_back.sv]
// Output stage: rounds and signs the quotient, holds the result for the consumer.
// Depends on qalu_pkg.
`default_nettype none

module qalu_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       in_valid,
	input  wire qalu_pkg::chain_t in_data,
	output logic            out_valid,
	output logic [qalu_pkg::WORD_W-1:0] out_value,
	output logic            out_lt,
	output logic            out_eq,
	output logic            out_gt,
	output logic            out_dz
);
	import qalu_pkg::*;

	logic [QUO_W:0]    q_sum;
	logic [WORD_W-1:0] q_mag;
	logic [WORD_W-1:0] value_d;
	logic              valid_q;
	logic [WORD_W-1:0] value_q;
	logic              lt_q, eq_q, gt_q, dz_q;

	// quotient carries one extra bit: (q2 + 1) >> 1 rounds half away from zero
	assign q_sum   = {1'b0, in_data.quo} + (QUO_W+1)'(1);
	assign q_mag   = q_sum[WORD_W:1];
	assign value_d = in_data.is_div ? (in_data.neg ? (WORD_W'(0) - q_mag) : q_mag)
	                                : in_data.res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= value_d;
			lt_q    <= in_data.lt;
			eq_q    <= in_data.eq;
			gt_q    <= in_data.gt;
			dz_q    <= in_data.dz;
		end
	end

	assign out_valid = valid_q;
	assign out_value = value_q;
	assign out_lt    = lt_q;
	assign out_eq    = eq_q;
	assign out_gt    = gt_q;
	assign out_dz    = dz_q;

endmodule

`default_nettype wire

[design/fixed_point_q24_8_alu.sv]
// Q24.8 fixed-point ALU top level: front end, a chain of divider cells, output stage.
// Depends on qalu_pkg, qalu_front, qalu_div_cell and qalu_back.
`default_nettype none

// Fully pipelined: one request is accepted every cycle unless req_stall is high, and every
// operation passes through the same stages (front stages, one divider cell per quotient
// bit of |a| << 9, output register), so results leave in request order. The whole
// pipeline advances together; it holds only while a result waits in the output
// register with rsp_stall high, and req_stall follows that condition.
module fixed_point_q24_8_alu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [3:0]  req_type,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [31:0]      result_value,
	output logic             less_than,
	output logic             equal_to,
	output logic             greater_than,
	output logic             div_by_zero
);
	import qalu_pkg::*;

	logic   en;
	logic   cv [DIVD_W+1];
	chain_t cd [DIVD_W+1];

	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	qalu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req_valid),
		.req_type  (req_type),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (cv[0]),
		.out_data  (cd[0])
	);

	for (genvar i = 0; i < DIVD_W; i++) begin : g_cell
		qalu_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cv[i]),
			.in_data   (cd[i]),
			.out_valid (cv[i+1]),
			.out_data  (cd[i+1])
		);
	end

	qalu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cv[DIVD_W]),
		.in_data   (cd[DIVD_W]),
		.out_valid (rsp_valid),
		.out_value (result_value),
		.out_lt    (less_than),
		.out_eq    (equal_to),
		.out_gt    (greater_than),
		.out_dz    (div_by_zero)
	);

endmodule

`default_nettype wire

[sim/qalu_checker.sv]
// Checker for the Q24.8 fixed-point ALU: watches both channels, predicts each result.
// Depends on qalu_pkg; instantiated beside the block by tb_fixed_point_q24_8_alu.
`timescale 1ns / 1ps

module qalu_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	input  wire logic        req_stall,
	input  wire logic [3:0]  req_type,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	input  wire logic        rsp_valid,
	input  wire logic        rsp_stall,
	input  wire logic [31:0] result_value,
	input  wire logic        less_than,
	input  wire logic        equal_to,
	input  wire logic        greater_than,
	input  wire logic        div_by_zero,
	output int               err_count,
	output int               pending
);
	import qalu_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic        lt;
		logic        eq;
		logic        gt;
		logic        dz;
	} alu_result_t;

	alu_result_t expected_results[$];

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic alu_result_t alu_compute(input logic [3:0] op, input logic [31:0] ua,
			input logic [31:0] ub);
		alu_result_t r;
		logic signed [63:0] sa, sb, prod;
		logic [63:0] m, num, den, q;
		r = '0;
		sa = $signed(ua);
		sb = $signed(ub);
		case (op)
			OP_ADD: r.value = ua + ub;
			OP_SUB: r.value = ua - ub;
			OP_MUL: begin
				prod = sa * sb;
				m = (mag(prod) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
				r.value = prod < 0 ? -m[31:0] : m[31:0];
			end
			OP_DIV: begin
				if (ub == 0) begin
					r.value = ua;
					r.dz = 1'b1;
				end else begin
					num = mag(sa) << FRAC_BITS;
					den = mag(sb);
					q = (2 * num + den) / (2 * den);
					r.value = ((sa < 0) != (sb < 0)) ? -q[31:0] : q[31:0];
				end
			end
			OP_CMP: begin
				r.lt = sa < sb;
				r.eq = sa == sb;
				r.gt = sa > sb;
			end
			OP_MIN: r.value = sa < sb ? ua : ub;
			OP_MAX: r.value = sa > sb ? ua : ub;
			OP_INC: r.value = ua + 1;
			OP_DEC: r.value = ua - 1;
			OP_TO_INT: r.value = $signed(ua) >>> FRAC_BITS;
			OP_FROM_INT: r.value = ua << FRAC_BITS;
			default: r = '0;
		endcase
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		alu_result_t e;
		if (!arst_n) begin
			err_count <= 0;
		end else begin
			if (req_valid && !req_stall)
				expected_results.push_back(alu_compute(req_type, operand_a, operand_b));
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: %h", result_value);
					err_count <= err_count + 1;
				end else begin
					e = expected_results.pop_front();
					if (e.value !== result_value ||
							e.lt !== less_than || e.eq !== equal_to ||
							e.gt !== greater_than || e.dz !== div_by_zero)
						err_count <= err_count + 1;
					if (e.value !== result_value)
						$error("result_value exp %h got %h", e.value, result_value);
					if (e.lt !== less_than)
						$error("less_than exp %b got %b", e.lt, less_than);
					if (e.eq !== equal_to)
						$error("equal_to exp %b got %b", e.eq, equal_to);
					if (e.gt !== greater_than)
						$error("greater_than exp %b got %b", e.gt, greater_than);
					if (e.dz !== div_by_zero)
						$error("div_by_zero exp %b got %b", e.dz, div_by_zero);
				end
			end
		end
	end

endmodule

[sim/tb_fixed_point_q24_8_alu.sv]
// Testbench top for the Q24.8 fixed-point ALU: directed and random requests, verdict.
// Depends on qalu_pkg, fixed_point_q24_8_alu and qalu_checker.
`timescale 1ns / 1ps

module tb_fixed_point_q24_8_alu;
	import qalu_pkg::*;

	localparam int LATENCY    = 45;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [3:0]  req_type = '0;
	logic [31:0] operand_a = '0;
	logic [31:0] operand_b = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [31:0] result_value;
	logic        less_than, equal_to, greater_than, div_by_zero;
	int          err_count, pending;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          hold_rx = 1'b0;
	int          cycles = 0;

	always #4 clk = ~clk;

	fixed_point_q24_8_alu u_dut (.*);

	qalu_checker u_chk (.*);

	// receiver: random stall, or a long hold when asked
	always @(posedge clk) begin
		int n;
		if (hold_rx) begin
			rsp_stall <= 1'b1;
			for (n = 0; n < 120; n++)
				@(posedge clk);
			rsp_stall <= 1'b0;
			hold_rx = 1'b0;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(5))
			0: return 32'h8000_0000 + $urandom_range(3);
			1: return 32'h7fff_ffff - $urandom_range(3);
			2: return $urandom_range(1023) - 512;
			3: return ($urandom_range(200) - 100) << FRAC_BITS;
			4: return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic send_random(input int count);
		logic [3:0] op;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(19) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(10));
			send_request(op, rand_operand(), $urandom_range(7) == 0 ? '0 : rand_operand());
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		opcode_t op;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each opcode on extremes, zero divisor, rounding ties, an unused code
		op = op.first();
		do begin
			send_request(op, 32'h7fff_ffff, 32'h8000_0000);
			send_request(op, 32'h8000_0000, 32'hffff_ffff);
			op = op.next();
		end while (op != op.first());
		send_request(OP_DIV, 32'h0000_1234, 32'h0);
		send_request(OP_MUL, 32'h0000_0180, 32'h0000_0001);
		send_request(OP_MUL, 32'hffff_fe80, 32'h0000_0001);
		send_request(4'd15, 32'hffff_ffff, 32'hffff_ffff);
		drain();

		send_idle_pct = 32; recv_idle_pct = 49;
		send_random(550);
		hold_rx = 1'b1;
		send_random(200);
		drain();
		send_idle_pct = 49; recv_idle_pct = 32;
		send_random(500);
		send_idle_pct = 0; recv_idle_pct = 0;
		send_random(500);
		drain();

		repeat (LATENCY + 10) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
